// ===== sv/pbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsf_pkg
// Shared types, constants and helper functions for the protobuf scalar
// field encoder: encoding kinds, wire types and varint byte packing.
// ----------------------------------------------------------------------------
package pbsf_pkg;

    // Field geometry.
    localparam int IndexW   = 29;
    localparam int ValueW   = 64;
    localparam int MaxBytes = 15;
    localparam int BufW     = MaxBytes * 8;
    localparam int CountW   = 4;
    localparam int TagW     = IndexW + 3;

    // A varint of 64 bits spans ten groups of seven bits.
    localparam int VarGroups = 10;
    localparam int VarBitsW  = VarGroups * 7;
    localparam int VarBytesW = VarGroups * 8;

    localparam logic [7:0] ContBit = 8'h80;

    // Encoding kinds carried on the input user bits.
    typedef enum logic [1:0] {
        ENC_VARINT  = 2'd0,
        ENC_ZIGZAG  = 2'd1,
        ENC_FIXED32 = 2'd2,
        ENC_FIXED64 = 2'd3
    } enc_kind_t;

    // Protobuf wire types.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // Encoded field handed from the encoder to the byte serializer.
    typedef struct packed {
        logic [BufW-1:0]   bytes;
        logic [CountW-1:0] count;
    } enc_field_t;

    // Number of bytes a varint of this value takes (one to ten).
    function automatic logic [CountW-1:0] varint_len(input logic [ValueW-1:0] v);
        logic [VarBitsW-1:0] w;
        logic [CountW-1:0]   n;
        w = VarBitsW'(v);
        n = CountW'(1);
        for (int i = 1; i < VarGroups; i++) begin
            if (|w[7*i +: 7]) begin
                n = CountW'(i + 1);
            end
        end
        return n;
    endfunction

    // Varint bytes of a value, first byte lowest; bytes past len are zero.
    function automatic logic [VarBytesW-1:0] varint_bytes(input logic [ValueW-1:0] v,
                                                          input logic [CountW-1:0] len);
        logic [VarBitsW-1:0]  w;
        logic [VarBytesW-1:0] b;
        w = VarBitsW'(v);
        b = '0;
        for (int i = 0; i < VarGroups; i++) begin
            b[8*i +: 8] = {(CountW'(i + 1) < len), w[7*i +: 7]};
        end
        return b;
    endfunction

endpackage

// ===== sv/pbsf_field_enc.sv =====
// ----------------------------------------------------------------------------
// pbsf_field_enc
// Combinational encoder: builds the tag varint and the value bytes of one
// field and packs them into a byte buffer with a byte count.
// ----------------------------------------------------------------------------
module pbsf_field_enc
    import pbsf_pkg::*;
(
    input  logic [IndexW-1:0] field_index,
    input  enc_kind_t         encoding,
    input  logic              is_float,
    input  logic [ValueW-1:0] value,
    output enc_field_t        field
);

    logic [IndexW-1:0]    number;
    logic [2:0]           wire_type;
    logic                 is_zero;
    logic [TagW-1:0]      tag;
    logic [CountW-1:0]    tag_len;
    logic [VarBytesW-1:0] tag_bytes;
    logic [ValueW-1:0]    zz_value;
    logic [ValueW-1:0]    var_src;
    logic [CountW-1:0]    val_len;
    logic [VarBytesW-1:0] val_bytes;
    logic [BufW-1:0]      val_wide;
    logic [BufW-1:0]      val_placed;

    // Field number wraps in its own width.
    assign number = field_index + IndexW'(1);

    // Zero test and wire type per encoding.
    always_comb begin
        case (encoding)
            ENC_FIXED32: begin
                wire_type = WT_FIXED32;
                is_zero   = (value[31:0] == 32'h0)
                         || (is_float && (value[31:0] == 32'h8000_0000));
            end
            ENC_FIXED64: begin
                wire_type = WT_FIXED64;
                is_zero   = (value == 64'h0)
                         || (is_float && (value == 64'h8000_0000_0000_0000));
            end
            default: begin
                wire_type = WT_VARINT;
                is_zero   = (value == 64'h0);
            end
        endcase
    end

    // Tag varint.
    assign tag       = {number, wire_type};
    assign tag_len   = varint_len(ValueW'(tag));
    assign tag_bytes = varint_bytes(ValueW'(tag), tag_len);

    // Zigzag maps the sign into bit zero.
    assign zz_value = {value[ValueW-2:0], 1'b0} ^ {ValueW{value[ValueW-1]}};
    assign var_src  = (encoding == ENC_ZIGZAG) ? zz_value : value;

    // Value bytes and their count.
    always_comb begin
        case (encoding)
            ENC_FIXED32: begin
                val_len   = CountW'(4);
                val_bytes = VarBytesW'(value[31:0]);
            end
            ENC_FIXED64: begin
                val_len   = CountW'(8);
                val_bytes = VarBytesW'(value);
            end
            default: begin
                val_len   = varint_len(var_src);
                val_bytes = varint_bytes(var_src, val_len);
            end
        endcase
    end

    // Place the value bytes right after the tag, which is one to five bytes.
    assign val_wide = BufW'(val_bytes);
    always_comb begin
        case (tag_len)
            CountW'(1): val_placed = val_wide << 8;
            CountW'(2): val_placed = val_wide << 16;
            CountW'(3): val_placed = val_wide << 24;
            CountW'(4): val_placed = val_wide << 32;
            default:    val_placed = val_wide << 40;
        endcase
    end

    // A zero value gives an empty field.
    always_comb begin
        field.bytes = BufW'(tag_bytes[39:0]) | val_placed;
        field.count = is_zero ? '0 : (tag_len + val_len);
    end

endmodule

// ===== sv/pbsf_byte_ser.sv =====
// ----------------------------------------------------------------------------
// pbsf_byte_ser
// Result register: holds one encoded field and shifts it out one byte per
// word, marking the final byte. Reloads in the cycle the final byte leaves.
// ----------------------------------------------------------------------------
module pbsf_byte_ser
    import pbsf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_valid,
    output logic       load_ready,
    input  enc_field_t load_field,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte [7:0]
    output logic       m_tlast
);

    logic [BufW-1:0]   buf_reg;
    logic [BufW-1:0]   buf_next;
    logic [CountW-1:0] cnt_reg;
    logic [CountW-1:0] cnt_next;
    logic              load;
    logic              take;

    assign m_tvalid   = (cnt_reg != '0);
    assign m_tlast    = (cnt_reg == CountW'(1));
    assign m_tdata    = buf_reg[7:0];
    assign take       = m_tvalid && m_tready;
    assign load_ready = !m_tvalid || (take && m_tlast);
    assign load       = load_valid && load_ready;

    // Load a new field or shift out the byte just taken.
    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = load_field.bytes;
            cnt_next = load_field.count;
        end else if (take) begin
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg - CountW'(1);
        end
    end

    // Byte buffer carries no reset.
    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    // Byte count is control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // A byte that is not the last is always followed by another.
    a_follow_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !m_tlast) |=> m_tvalid)
        else $error("pbsf_byte_ser: field cut short");

    // The next byte is the one behind the byte taken.
    a_shift_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !m_tlast) |=> (m_tdata == $past(buf_reg[15:8])))
        else $error("pbsf_byte_ser: byte order broken");

    // After the last byte with no reload, the output goes idle.
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && m_tlast && !load_valid) |=> !m_tvalid)
        else $error("pbsf_byte_ser: byte invented after last");

    // A loaded non-empty field shows its first byte next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (load_field.count != '0)) |=>
            (m_tvalid && (m_tdata == $past(load_field.bytes[7:0]))))
        else $error("pbsf_byte_ser: loaded field not presented");

endmodule

// ===== sv/protobuf_scalar_field_encoder_unit.sv =====
// The first byte of a field is offered once the field has passed the input register and
// been loaded into the byte register, which takes it only when the byte register is free.
// Throughput: one output byte per cycle while m_tready is high; a field holds 2 to 15 bytes,
// and a zero field passes through the input register without giving any output byte.
// The input register takes a new field while the byte register still drains the last one.
// Reset: synchronous active-low aresetn empties both registers; no outputs follow reset.
// ----------------------------------------------------------------------------
// protobuf_scalar_field_encoder_unit
// Encodes one scalar field per input word into protobuf wire bytes: tag
// varint followed by a varint, zigzag varint, fixed32 or fixed64 value.
// ----------------------------------------------------------------------------
module protobuf_scalar_field_encoder_unit
    import pbsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // field_index [28:0], value [92:29], zero [95:93]
    input  logic [2:0]  s_tuser,   // encoding [1:0], is_float [2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast    // last_byte
);

    logic              in_valid_reg;
    logic [IndexW-1:0] in_index_reg;
    enc_kind_t         in_enc_reg;
    logic              in_float_reg;
    logic [ValueW-1:0] in_value_reg;
    logic              ser_ready;
    logic              s_take;
    enc_field_t        enc_field;

    assign s_tready = !in_valid_reg || ser_ready;
    assign s_take   = s_tvalid && s_tready;

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_index_reg <= s_tdata[IndexW-1:0];
            in_value_reg <= s_tdata[IndexW +: ValueW];
            in_enc_reg   <= enc_kind_t'(s_tuser[1:0]);
            in_float_reg <= s_tuser[2];
        end
    end

    // Input register occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Field encoder between the two registers.
    pbsf_field_enc u_enc (
        .field_index (in_index_reg),
        .encoding    (in_enc_reg),
        .is_float    (in_float_reg),
        .value       (in_value_reg),
        .field       (enc_field)
    );

    // Byte serializer holding the result.
    pbsf_byte_ser u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_ready (ser_ready),
        .load_field (enc_field),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== dv/pbsf_checker.sv =====
// ----------------------------------------------------------------------------
// pbsf_checker
// Watches both stream channels of the scalar field encoder. It works out the
// wire bytes of every accepted input word and compares each output word,
// data and last flag, with the oldest byte still expected.
// ----------------------------------------------------------------------------
module pbsf_checker
    import pbsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // field_index [28:0], value [92:29], zero [95:93]
    input  logic [2:0]  s_tuser,   // encoding [1:0], is_float [2]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // out_byte [7:0]
    input  logic        m_tlast,   // last_byte
    output int          mismatch_count,
    output int          bytes_pending,
    output int          bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    // Wire bytes still owed by the block, oldest first.
    wire_byte_t wire_bytes_q[$];

    // Scratch space for the encoding of one field.
    logic [7:0] field_buf [MaxBytes];
    int         field_len;

    task automatic report_mismatch(input string what);
        $display("[%0t] checker: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Appends a base-128 varint, low group first, continuation bit on all
    // groups but the final one.
    task automatic add_varint(input logic [63:0] v);
        logic [63:0] rest;
        rest = v;
        while (rest >= 64'(ContBit)) begin
            field_buf[field_len] = ContBit | {1'b0, rest[6:0]};
            field_len++;
            rest = rest >> 7;
        end
        field_buf[field_len] = rest[7:0];
        field_len++;
    endtask

    // Appends the low bytes of a value in little-endian order.
    task automatic add_fixed(input logic [63:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            field_buf[field_len] = v[8*i +: 8];
            field_len++;
        end
    endtask

    // Works out the wire bytes of one field and queues them.
    task automatic queue_field_bytes(input logic [IndexW-1:0] idx, input enc_kind_t enc,
                                     input logic flt, input logic [63:0] val);
        logic [IndexW-1:0] number;
        logic [2:0]        wt;
        logic [63:0]       v;
        logic              is_zero;
        // The field number is kept to the index width, so the top index wraps to zero.
        number = idx + 1'b1;
        v      = val;
        case (enc)
            ENC_FIXED32: begin
                v       = {32'h0, val[31:0]};
                is_zero = (v == 64'h0) || (flt && v == 64'h8000_0000);
                wt      = WT_FIXED32;
            end
            ENC_FIXED64: begin
                is_zero = (v == 64'h0) || (flt && v == 64'h8000_0000_0000_0000);
                wt      = WT_FIXED64;
            end
            default: begin
                is_zero = (v == 64'h0);
                wt      = WT_VARINT;
            end
        endcase
        field_len = 0;
        if (!is_zero) begin
            add_varint(64'({number, wt}));
            case (enc)
                ENC_VARINT:  add_varint(v);
                ENC_ZIGZAG:  add_varint({v[62:0], 1'b0} ^ {64{v[63]}});
                ENC_FIXED32: add_fixed(v, 4);
                default:     add_fixed(v, 8);
            endcase
            for (int i = 0; i < field_len; i++) begin
                wire_bytes_q.push_back('{data: field_buf[i], last: (i == field_len - 1)});
            end
        end
    endtask

    // Output words are compared before new expectations are queued, since a
    // field accepted at this edge cannot have produced a byte yet.
    always @(posedge aclk) begin
        wire_byte_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (wire_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %02h last %0b",
                                              m_tdata, m_tlast));
                end else begin
                    want = wire_bytes_q.pop_front();
                    if (m_tdata !== want.data) begin
                        report_mismatch($sformatf("word %0d data %02h, expected %02h",
                                                  bytes_checked, m_tdata, want.data));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("word %0d last %0b, expected %0b",
                                                  bytes_checked, m_tlast, want.last));
                    end
                end
                bytes_checked++;
            end
            if (s_tvalid && s_tready) begin
                queue_field_bytes(s_tdata[28:0], enc_kind_t'(s_tuser[1:0]), s_tuser[2],
                                  s_tdata[92:29]);
            end
        end
        bytes_pending = wire_bytes_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the protobuf scalar field encoder. Directed
// fields cover the extremes and the zero rules of every encoding; random
// fields follow in phases with random gaps, no gaps, and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pbsf_pkg::*;

    localparam int CycleLimit    = 200000;
    localparam int LongHold      = 300;
    localparam int TailCycles    = 20;
    localparam int FieldsPerPhase = 37;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;   // field_index [28:0], value [92:29], zero [95:93]
    logic [2:0]  s_tuser  = '0;   // encoding [1:0], is_float [2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // out_byte [7:0]
    logic        m_tlast;         // last_byte

    int mismatch_count;
    int bytes_pending;
    int bytes_checked;
    int cycle_count   = 0;
    int fields_sent   = 0;

    // Idle controls for the sender and the receiver.
    logic send_idle     = 1'b1;
    logic recv_idle     = 1'b1;
    logic long_hold_req = 1'b0;

    protobuf_scalar_field_encoder_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pbsf_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending),
        .bytes_checked  (bytes_checked)
    );

    always #5 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles, %0d bytes still owed", cycle_count,
                     bytes_pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one field after a drawn gap and holds it until it is taken.
    task automatic send_field(input logic [IndexW-1:0] idx, input enc_kind_t enc,
                              input logic flt, input logic [63:0] val);
        int gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, val, idx};
        s_tuser  <= {flt, enc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fields_sent++;
    endtask

    // Random field: mostly short values and small indexes, with sign-extended
    // negatives, both zeros and the extreme indexes mixed in.
    task automatic send_random_field();
        logic [IndexW-1:0] idx;
        logic [63:0]       val;
        logic [63:0]       mask;
        int                nbits;
        case ($urandom_range(0, 3))
            0:       idx = IndexW'($urandom_range(0, 30));
            1:       idx = IndexW'($urandom());
            2:       idx = {IndexW{1'b1}} - IndexW'($urandom_range(0, 1));
            default: idx = IndexW'($urandom_range(0, 20000));
        endcase
        nbits = $urandom_range(0, 64);
        mask  = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
        val   = {$urandom(), $urandom()} & mask;
        case ($urandom_range(0, 9))
            0:       val = ~val;
            1:       val = 64'h0;
            2:       val = 64'h8000_0000_0000_0000;
            3:       val = {$urandom(), 32'h8000_0000};
            default: ;
        endcase
        send_field(idx, enc_kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), val);
    endtask

    // Receiver: a drawn wait before each word, or one long hold on request.
    initial begin
        int rgap;
        wait (aresetn);
        forever begin
            if (long_hold_req) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (LongHold) @(negedge aclk);
                long_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                rgap = recv_idle ? $urandom_range(0, 9) : 0;
                @(negedge aclk);
                if (rgap > 0) begin
                    m_tready <= 1'b0;
                    repeat (rgap) @(negedge aclk);
                end
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Main sequence.
    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed fields: tag lengths, value lengths and the zero rules.
        send_field(29'd0, ENC_VARINT, 1'b0, 64'd1);
        send_field(29'd14, ENC_VARINT, 1'b0, 64'd127);
        send_field(29'd15, ENC_VARINT, 1'b0, 64'd128);
        send_field(29'd536870910, ENC_VARINT, 1'b1, '1);
        send_field('1, ENC_VARINT, 1'b0, 64'd1);
        send_field('1, ENC_FIXED64, 1'b0, '1);
        send_field(29'd3, ENC_VARINT, 1'b0, 64'd0);
        send_field(29'd3, ENC_VARINT, 1'b1, 64'd0);
        send_field(29'd4, ENC_VARINT, 1'b1, 64'h8000_0000_0000_0000);
        send_field(29'd5, ENC_ZIGZAG, 1'b0, '1);
        send_field(29'd5, ENC_ZIGZAG, 1'b0, 64'd1);
        send_field(29'd6, ENC_ZIGZAG, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_field(29'd536870910, ENC_ZIGZAG, 1'b0, 64'h8000_0000_0000_0000);
        send_field(29'd6, ENC_ZIGZAG, 1'b1, 64'd0);
        send_field(29'd7, ENC_FIXED32, 1'b0, 64'd0);
        send_field(29'd7, ENC_FIXED32, 1'b0, 64'hFFFF_FFFF_0000_0000);
        send_field(29'd8, ENC_FIXED32, 1'b1, 64'h8000_0000);
        send_field(29'd8, ENC_FIXED32, 1'b0, 64'h8000_0000);
        send_field(29'd9, ENC_FIXED32, 1'b1, 64'hFFFF_FFFF_8000_0000);
        send_field(29'd9, ENC_FIXED32, 1'b1, 64'hA5A5_A5A5_1234_5678);
        send_field(29'd10, ENC_FIXED64, 1'b0, 64'd0);
        send_field(29'd10, ENC_FIXED64, 1'b1, 64'h8000_0000_0000_0000);
        send_field(29'd11, ENC_FIXED64, 1'b0, 64'h8000_0000_0000_0000);
        send_field(29'd11, ENC_FIXED64, 1'b1, 64'h8000_0000);

        // Random phases: random gaps, no gaps, long output stall, random gaps.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle = (phase != 1) && (phase != 2);
            recv_idle = (phase != 1);
            if (phase == 2) begin
                long_hold_req = 1'b1;
            end
            repeat (FieldsPerPhase) send_random_field();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray word.
        wait (bytes_pending == 0);
        repeat (TailCycles) @(posedge aclk);

        $display("Covered %0d fields over all four encodings, with random gaps,", fields_sent);
        $display("a no-idle stretch and a %0d-cycle output stall; %0d words compared.",
                 LongHold, bytes_checked);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
